// ===== rtl/core/dcs_pkg.sv =====
// Shared types, constants and helpers for the distance constraint solver.
// Used by every module under rtl/core; depends on nothing else.
package dcs_pkg;

  // Default fraction width of the Q format
  localparam int FracBitsDef = 16;

  // Pipeline depths of the iterative units, and the divider lane count
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;
  localparam int DivLanes  = 6;

  // Register field widths
  localparam int RestW  = 31;
  localparam int ElastW = 18;
  localparam int ShareW = 17;
  localparam int StepW  = 19;

  // APB address width: five word registers
  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    RegRest   = 3'd0,
    RegElast  = 3'd1,
    RegShareA = 3'd2,
    RegShareB = 3'd3,
    RegStep   = 3'd4
  } dcs_reg_e;

  typedef logic signed [31:0] dcs_word_t;
  typedef dcs_word_t [2:0] dcs_vec_t;

  typedef struct packed {
    logic [RestW-1:0]  rest_distance;
    logic [ElastW-1:0] elasticity;
    logic [ShareW-1:0] share_a;
    logic [ShareW-1:0] share_b;
    logic [StepW-1:0]  step_ratio;
  } dcs_cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
  } dcs_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] new_vel_b_z;
    logic               corrected;
  } dcs_out_t;

  // Connector and both velocities, carried beside the length computation
  typedef struct packed {
    dcs_vec_t c;
    dcs_vec_t va;
    dcs_vec_t vb;
  } dcs_side_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/dcs_regs.sv =====
// APB register file for the solver configuration.
// Depends on dcs_pkg.
module dcs_regs #(
  parameter int FRAC_BITS = dcs_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output dcs_pkg::dcs_cfg_t        cfg_o
);
  import dcs_pkg::*;

  dcs_cfg_t cfg_q;
  dcs_reg_e idx;
  logic     wr;

  assign idx   = dcs_reg_e'(paddr[AddrW-1:2]);
  assign wr    = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_distance <= RestW'(1) << FRAC_BITS;
      cfg_q.elasticity    <= '0;
      cfg_q.share_a       <= ShareW'(1) << (FRAC_BITS - 1);
      cfg_q.share_b       <= ShareW'(1) << (FRAC_BITS - 1);
      cfg_q.step_ratio    <= StepW'(1) << FRAC_BITS;
    end else if (wr) begin
      case (idx)
        RegRest:   cfg_q.rest_distance <= pwdata[RestW-1:0];
        RegElast:  cfg_q.elasticity    <= pwdata[ElastW-1:0];
        RegShareA: cfg_q.share_a       <= pwdata[ShareW-1:0];
        RegShareB: cfg_q.share_b       <= pwdata[ShareW-1:0];
        RegStep:   cfg_q.step_ratio    <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegRest:   prdata = 32'(cfg_q.rest_distance);
      RegElast:  prdata = 32'(cfg_q.elasticity);
      RegShareA: prdata = 32'(cfg_q.share_a);
      RegShareB: prdata = 32'(cfg_q.share_b);
      RegStep:   prdata = 32'(cfg_q.step_ratio);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/dcs_front.sv =====
// Front stages: position prediction, connector, squares and their sum.
// Depends on dcs_pkg.
module dcs_front #(
  parameter int FRAC_BITS = dcs_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dcs_pkg::dcs_in_t       data_i,
  input  logic [dcs_pkg::StepW-1:0] step_i,
  output logic                   valid_o,
  output logic [63:0]            sum_o,
  output dcs_pkg::dcs_side_t     side_o
);
  import dcs_pkg::*;

  localparam int ProdW = 32 + StepW + 1;

  dcs_vec_t pa, pb, va, vb;
  assign pa = {data_i.pos_a_z, data_i.pos_a_y, data_i.pos_a_x};
  assign pb = {data_i.pos_b_z, data_i.pos_b_y, data_i.pos_b_x};
  assign va = {data_i.vel_a_z, data_i.vel_a_y, data_i.vel_a_x};
  assign vb = {data_i.vel_b_z, data_i.vel_b_y, data_i.vel_b_x};

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic signed [ProdW-1:0] mpa_q [3];
  logic signed [ProdW-1:0] mpb_q [3];
  dcs_vec_t                pa1_q, pb1_q, va1_q, vb1_q;
  dcs_side_t               s2_q, s3_q, s4_q;
  logic [63:0]             sq3_q [3];
  logic [63:0]             sum4_q;
  dcs_side_t               s2_d;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 2 logic: predicted positions and saturated connector
  always_comb begin
    logic signed [ProdW:0] preda, predb;
    logic signed [ProdW+1:0] diff;
    s2_d.va = va1_q;
    s2_d.vb = vb1_q;
    for (int i = 0; i < 3; i++) begin
      preda = (ProdW+1)'(pa1_q[i]) + (ProdW+1)'(mpa_q[i] >>> FRAC_BITS);
      predb = (ProdW+1)'(pb1_q[i]) + (ProdW+1)'(mpb_q[i] >>> FRAC_BITS);
      diff  = (ProdW+2)'(preda) - (ProdW+2)'(predb);
      s2_d.c[i] = sat32(64'(diff));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: velocity times step ratio
      for (int i = 0; i < 3; i++) begin
        mpa_q[i] <= va[i] * $signed({1'b0, step_i});
        mpb_q[i] <= vb[i] * $signed({1'b0, step_i});
      end
      pa1_q <= pa;
      pb1_q <= pb;
      va1_q <= va;
      vb1_q <= vb;
      // stage 2
      s2_q <= s2_d;
      // stage 3: squares
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= 64'(s2_q.c[i] * s2_q.c[i]);
      end
      s3_q <= s2_q;
      // stage 4: sum of squares
      sum4_q <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      s4_q   <= s3_q;
    end
  end

  assign valid_o = v4_q;
  assign sum_o   = sum4_q;
  assign side_o  = s4_q;

endmodule

// ===== rtl/core/dcs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on dcs_pkg.
module dcs_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);
  import dcs_pkg::*;

  logic [33:0] rem_q  [SqrtSteps];
  logic [31:0] root_q [SqrtSteps];
  logic [63:0] x_q    [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] x_in;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    // bring down two bits, try subtracting 4*root+1
    assign shifted = {rem_in, x_in[63:62]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 34'(shifted - trial) : shifted[33:0];
        root_q[k] <= {root_in[30:0], ge};
        x_q[k]    <= {x_in[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SqrtSteps-1];

endmodule

// ===== rtl/core/dcs_div.sv =====
// Pipelined unsigned divider, several lanes sharing one divisor.
// Quotient must fit 32 bits. Depends on dcs_pkg.
module dcs_div #(
  parameter int LANES = dcs_pkg::DivLanes
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [31:0]            den_i,
  input  logic [LANES-1:0][63:0] num_i,
  output logic [LANES-1:0][31:0] quo_o
);
  import dcs_pkg::*;

  // upper half holds the remainder, lower half shifts in quotient bits
  logic [LANES-1:0][63:0] acc_q [DivSteps];
  logic [31:0]            den_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [LANES-1:0][63:0] acc_in;
    logic [LANES-1:0][63:0] acc_d;
    logic [31:0]            den_in;

    if (k == 0) begin : g_first
      assign acc_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign acc_in = acc_q[k-1];
      assign den_in = den_q[k-1];
    end

    // one compare and subtract per lane
    always_comb begin
      logic [64:0] sh;
      logic [32:0] top;
      for (int l = 0; l < LANES; l++) begin
        sh  = {acc_in[l], 1'b0};
        top = sh[64:32];
        if (top >= {1'b0, den_in}) begin
          top = top - {1'b0, den_in};
          acc_d[l] = {top[31:0], sh[31:1], 1'b1};
        end else begin
          acc_d[l] = {top[31:0], sh[31:1], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_d;
        den_q[k] <= den_in;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = acc_q[DivSteps-1][l][31:0];
  end

endmodule

// ===== rtl/core/dcs_back.sv =====
// Back stages: length error, correction magnitudes, resize and final sum.
// Depends on dcs_pkg and dcs_div.
module dcs_back #(
  parameter int FRAC_BITS = dcs_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        len_i,
  input  dcs_pkg::dcs_side_t side_i,
  input  dcs_pkg::dcs_cfg_t  cfg_i,
  output logic               valid_o,
  output dcs_pkg::dcs_out_t  data_o
);
  import dcs_pkg::*;

  localparam int RawW   = 34;
  localparam int MulW   = (FRAC_BITS + 2 > ElastW + 1) ? FRAC_BITS + 2 : ElastW + 1;
  localparam int EProdW = RawW + MulW;
  localparam int ErrW   = 53 - FRAC_BITS;
  localparam int MagW   = ErrW + ShareW + 1;
  localparam logic signed [ErrW-1:0] ThreshQ = ErrW'(((1 << FRAC_BITS) + 50) / 100);

  // valid chain through the five pre-divide stages
  logic [4:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // stage 1: raw error times elasticity (or times one when unscaled)
  logic signed [RawW-1:0]   err_raw;
  logic [MulW-2:0]          mulf;
  logic signed [EProdW-1:0] eprod1_q;
  logic [31:0]              len1_q, len2_q, len3_q, len4_q, len5_q;
  dcs_side_t                s1_q, s2_q, s3_q, s4_q;

  assign err_raw = $signed({2'b00, len_i}) - $signed({3'b000, cfg_i.rest_distance});
  assign mulf    = (cfg_i.elasticity != '0) ? (MulW-1)'(cfg_i.elasticity)
                                            : (MulW-1)'(1) << FRAC_BITS;

  // stage 2: scaled error, threshold test, share products
  logic signed [ErrW-1:0] err2;
  logic                   corr2;
  logic signed [MagW-1:0] pa2_q, pb2_q;
  logic                   corr2_q, corr3_q, corr4_q, corr5_q;

  assign err2  = ErrW'(eprod1_q >>> FRAC_BITS);
  assign corr2 = (len1_q != '0) && ((err2 > ThreshQ) || (err2 < -ThreshQ));

  // stage 3: saturated magnitudes
  logic signed [31:0] ma3_q, mb3_q;

  // stage 4: connector times magnitude
  logic signed [63:0] pc4_q [6];

  // stage 5: sign and magnitude for the divider
  logic [DivLanes-1:0][63:0] num5_q;
  logic [DivLanes-1:0]       neg5_q;
  dcs_vec_t                  va5_q, vb5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eprod1_q <= err_raw * $signed({1'b0, mulf});
      len1_q   <= len_i;
      s1_q     <= side_i;

      pa2_q   <= (-MagW'(err2)) * $signed({1'b0, cfg_i.share_a});
      pb2_q   <= MagW'(err2) * $signed({1'b0, cfg_i.share_b});
      corr2_q <= corr2;
      len2_q  <= len1_q;
      s2_q    <= s1_q;

      ma3_q   <= sat32(64'(pa2_q >>> FRAC_BITS));
      mb3_q   <= sat32(64'(pb2_q >>> FRAC_BITS));
      corr3_q <= corr2_q;
      len3_q  <= len2_q;
      s3_q    <= s2_q;

      for (int i = 0; i < 3; i++) begin
        pc4_q[i]     <= 64'(s3_q.c[i] * ma3_q);
        pc4_q[3 + i] <= 64'(s3_q.c[i] * mb3_q);
      end
      corr4_q <= corr3_q;
      len4_q  <= len3_q;
      s4_q    <= s3_q;

      for (int l = 0; l < DivLanes; l++) begin
        neg5_q[l] <= pc4_q[l][63];
        num5_q[l] <= pc4_q[l][63] ? 64'(-pc4_q[l]) : 64'(pc4_q[l]);
      end
      corr5_q <= corr4_q;
      len5_q  <= len4_q;
      va5_q   <= s4_q.va;
      vb5_q   <= s4_q.vb;
    end
  end

  // divide by the length
  logic [DivLanes-1:0][31:0] quo;

  dcs_div #(
    .LANES (DivLanes)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .den_i (len5_q),
    .num_i (num5_q),
    .quo_o (quo)
  );

  // side line beside the divider
  typedef struct packed {
    dcs_vec_t            va;
    dcs_vec_t            vb;
    logic [DivLanes-1:0] neg;
    logic                corr;
  } dcs_dside_t;

  dcs_dside_t          ds_q [DivSteps];
  logic [DivSteps-1:0] dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en_i) begin
      dv_q <= {dv_q[DivSteps-2:0], v_q[4]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q[0] <= '{va: va5_q, vb: vb5_q, neg: neg5_q, corr: corr5_q};
      for (int k = 1; k < DivSteps; k++) begin
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  // final: add signed quotient to velocity, saturate, select
  dcs_dside_t  dl;
  dcs_out_t    out_d;
  dcs_vec_t    na, nb;

  assign dl          = ds_q[DivSteps-1];

  always_comb begin
    logic signed [32:0] q;
    logic signed [33:0] s;
    for (int l = 0; l < DivLanes; l++) begin
      q = dl.neg[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
      if (l < 3) begin
        s = 34'(dl.va[l]) + 34'(q);
        na[l] = dl.corr ? sat32(64'(s)) : dl.va[l];
      end else begin
        s = 34'(dl.vb[l-3]) + 34'(q);
        nb[l-3] = dl.corr ? sat32(64'(s)) : dl.vb[l-3];
      end
    end
    out_d.new_vel_a_x = na[0];
    out_d.new_vel_a_y = na[1];
    out_d.new_vel_a_z = na[2];
    out_d.new_vel_b_x = nb[0];
    out_d.new_vel_b_y = nb[1];
    out_d.new_vel_b_z = nb[2];
    out_d.corrected   = dl.corr;
  end

  // output register
  logic     vo_q;
  dcs_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/core/distance_constraint_solve.sv =====
// Distance link velocity correction, Q-format fixed point, top level.
// Depends on dcs_pkg, dcs_regs, dcs_front, dcs_sqrt, dcs_back.
//
// Input channel in_valid_i/in_ready_o carries one link item: positions and
// velocities of both masses. Output channel out_valid_o/out_ready_i returns
// the corrected velocities and a corrected flag, one result per item, in
// order. Configuration registers sit behind the APB port and must be
// written while the pipeline is empty; the user, not the block, ensures this.
//
// Throughput: one item per cycle unless out_ready_i stalls the output. An
// item passes 4 front stages, 32 square-root stages, 5 error and magnitude
// stages, 32 divider stages and the output register on its way to
// out_valid_o; the 32-stage root and divide pipelines make up most of it.
//
// Reset clears all valid bits and loads the register defaults (rest length
// 1.0, elasticity 0, shares 0.5, step ratio 1.0). When the receiver holds
// out_ready_i low with a result waiting, the whole pipeline freezes and
// in_ready_o drops; nothing is lost or repeated.
module distance_constraint_solve #(
  parameter int FRAC_BITS = dcs_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dcs_pkg::dcs_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dcs_pkg::dcs_out_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dcs_pkg::*;

  dcs_cfg_t  cfg;
  logic      en;
  logic      fv;
  logic [63:0] sum;
  dcs_side_t fside;
  logic [31:0] len;

  // pipeline advances unless a finished item is stuck at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  dcs_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcs_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .step_i  (cfg.step_ratio),
    .valid_o (fv),
    .sum_o   (sum),
    .side_o  (fside)
  );

  dcs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (sum),
    .root_o (len)
  );

  // connector and velocities ride beside the root pipeline
  dcs_side_t            side_q [SqrtSteps];
  logic [SqrtSteps-1:0] sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[SqrtSteps-2:0], fv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= fside;
      for (int k = 1; k < SqrtSteps; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  dcs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[SqrtSteps-1]),
    .len_i   (len),
    .side_i  (side_q[SqrtSteps-1]),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

// ===== verif/distance_constraint_solve_test.sv =====
// Testbench for distance_constraint_solve: random and directed link items,
// APB register phases, predicted velocity corrections checked in order.
// Depends on dcs_pkg and the distance_constraint_solve RTL.
`timescale 1ns / 100ps

module distance_constraint_solve_test;
  import dcs_pkg::*;

  localparam int Frac = 16;
  localparam longint Thresh = ((64'sd1 << Frac) + 50) / 100;
  localparam int PipeDepth = 74;

  // Scoreboard: holds link settings, predicts corrected velocities
  class link_scoreboard;
    logic [RestW-1:0]  rest_d;
    logic [ElastW-1:0] elast;
    logic [ShareW-1:0] sh_a;
    logic [ShareW-1:0] sh_b;
    logic [StepW-1:0]  step;
    dcs_out_t          pending_vel[$];
    int                n_errors;
    int                n_checked;
    int                n_corrected;

    function void set_defaults();
      rest_d = 65536;
      elast  = 0;
      sh_a   = 32768;
      sh_b   = 32768;
      step   = 65536;
    endfunction

    function void set_reg(dcs_reg_e idx, logic [31:0] v);
      case (idx)
        RegRest:   rest_d = v[RestW-1:0];
        RegElast:  elast  = v[ElastW-1:0];
        RegShareA: sh_a   = v[ShareW-1:0];
        RegShareB: sh_b   = v[ShareW-1:0];
        RegStep:   step   = v[StepW-1:0];
        default: ;
      endcase
    endfunction

    function longint fshift(longint v);
      return v >>> Frac;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint int_root(longint unsigned x);
      longint unsigned rem, root, b;
      rem  = x;
      root = 0;
      b    = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem  -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return longint'(root);
    endfunction

    // Predict the result for one accepted link item
    function void note_link(dcs_in_t d);
      longint pa[3], pb[3], va[3], vb[3], c[3], ra[3], rb[3];
      longint unsigned sq;
      longint len, err, ma, mb;
      dcs_out_t r;
      pa = '{d.pos_a_x, d.pos_a_y, d.pos_a_z};
      pb = '{d.pos_b_x, d.pos_b_y, d.pos_b_z};
      va = '{d.vel_a_x, d.vel_a_y, d.vel_a_z};
      vb = '{d.vel_b_x, d.vel_b_y, d.vel_b_z};
      sq = 0;
      r.corrected = 1'b0;
      for (int i = 0; i < 3; i++) begin
        pa[i] += fshift(va[i] * longint'(step));
        pb[i] += fshift(vb[i] * longint'(step));
        c[i] = sat(pa[i] - pb[i]);
        sq += longint'(c[i] * c[i]);
        ra[i] = va[i];
        rb[i] = vb[i];
      end
      len = int_root(sq);
      if (len > 0) begin
        err = len - longint'(rest_d);
        if (elast != 0) err = fshift(err * longint'(elast));
        if (err > Thresh || err < -Thresh) begin
          ma = sat(fshift(-err * longint'(sh_a)));
          mb = sat(fshift(err * longint'(sh_b)));
          for (int i = 0; i < 3; i++) begin
            ra[i] = sat(va[i] + (c[i] * ma) / len);
            rb[i] = sat(vb[i] + (c[i] * mb) / len);
          end
          r.corrected = 1'b1;
        end
      end
      r.new_vel_a_x = ra[0][31:0];
      r.new_vel_a_y = ra[1][31:0];
      r.new_vel_a_z = ra[2][31:0];
      r.new_vel_b_x = rb[0][31:0];
      r.new_vel_b_y = rb[1][31:0];
      r.new_vel_b_z = rb[2][31:0];
      pending_vel.push_back(r);
    endfunction

    function void field_cmp(string nm, longint e, longint a);
      if (e != a) begin
        n_errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, nm, e, a);
      end
    endfunction

    // Compare one output item with the oldest prediction
    function void check_result(dcs_out_t a);
      dcs_out_t e;
      if (pending_vel.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, got %h", $time, a);
        return;
      end
      e = pending_vel.pop_front();
      n_checked++;
      if (a.corrected) n_corrected++;
      field_cmp("new_vel_a_x", e.new_vel_a_x, a.new_vel_a_x);
      field_cmp("new_vel_a_y", e.new_vel_a_y, a.new_vel_a_y);
      field_cmp("new_vel_a_z", e.new_vel_a_z, a.new_vel_a_z);
      field_cmp("new_vel_b_x", e.new_vel_b_x, a.new_vel_b_x);
      field_cmp("new_vel_b_y", e.new_vel_b_y, a.new_vel_b_y);
      field_cmp("new_vel_b_z", e.new_vel_b_z, a.new_vel_b_z);
      field_cmp("corrected", e.corrected, a.corrected);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  dcs_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  dcs_out_t         out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  link_scoreboard sb;
  int  idle_pct_in;
  int  idle_pct_out;
  bit  hold_off;
  bit  hold_done;

  distance_constraint_solve i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // APB register write: setup then access cycle
  task automatic write_reg(dcs_reg_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Offer one item, hold it until accepted
  task automatic send_link(dcs_in_t d);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_link(d);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(8) << 16;
      3: return $urandom;
      default: return $signed($urandom_range(20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic dcs_in_t rnd_link();
    dcs_in_t d;
    logic [31:0] w[12];
    for (int i = 0; i < 12; i++) w[i] = rnd_word();
    // velocities mostly small so the prediction stays near the positions
    for (int i = 3; i < 6; i++) if ($urandom_range(2) != 0) w[i] = $signed(w[i]) >>> 8;
    for (int i = 9; i < 12; i++) if ($urandom_range(2) != 0) w[i] = $signed(w[i]) >>> 8;
    d = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
    return d;
  endfunction

  function automatic dcs_in_t make_link(int ax, int ay, int az, int bx, int by, int bz,
                                         int v);
    dcs_in_t d;
    d = {ax, ay, az, v, -v, v, bx, by, bz, -v, v, -v};
    return d;
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending_vel.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  // Output side: random stalls, one long hold-off
  initial begin
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_off && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct_out);
      end
    end
  end

  initial begin
    sb = new();
    sb.set_defaults();
    idle_pct_in  = 25;
    idle_pct_out = 25;
    hold_off   = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, zero connector, within threshold, extremes
    send_link('0);
    send_link(make_link(65536, 0, 0, 0, 0, 0, 0));
    send_link(make_link(65536 + 300, 0, 0, 0, 0, 0, 0));
    send_link(make_link(3 << 16, 0, 0, 0, 0, 0, 0));
    send_link(make_link(0, 0, 0, 0, 0, 100, 0));
    send_link(make_link(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000, 0));
    send_link(make_link(1, 2, 3, -5, 7, -9, 32'h7fffffff));
    send_link(make_link(1, 2, 3, -5, 7, -9, 32'h80000000));
    send_link({12{32'hffffffff}});
    send_link({12{32'h80000000}});
    send_link({12{32'h7fffffff}});
    send_link({6{32'h55555555, 32'haaaaaaaa}});
    drain();

    // Phases through several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegRest, 32'h7fffffff);
          write_reg(RegElast, 131072);
          write_reg(RegShareA, 65536);
          write_reg(RegShareB, 65536);
          write_reg(RegStep, 262144);
        end
        1: begin
          write_reg(RegRest, 0);
          write_reg(RegElast, 32'hffffffff);
          write_reg(RegShareA, 0);
          write_reg(RegShareB, 32'hffffffff);
          write_reg(RegStep, 0);
        end
        2: begin
          write_reg(RegRest, 32'hffffffff);
          write_reg(RegElast, 0);
          write_reg(RegShareA, 32'hffffffff);
          write_reg(RegShareB, 0);
          write_reg(RegStep, 32'hffffffff);
        end
        default: begin
          write_reg(RegRest, $urandom_range(8 << 16));
          write_reg(RegElast, $urandom_range(3) == 0 ? 0 : $urandom_range(131072));
          write_reg(RegShareA, $urandom_range(65536));
          write_reg(RegShareB, $urandom_range(65536));
          write_reg(RegStep, $urandom_range(262144));
        end
      endcase
      for (int n = 0; n < 105; n++) begin
        idle_pct_in  = (ph == 3) ? 0 : 25;
        idle_pct_out = (ph == 3) ? 0 : 25;
        if (ph == 4 && n == 5) hold_off = 1'b1;
        send_link(rnd_link());
      end
      drain();
    end

    $display("Checked %0d link results, %0d with a velocity correction,",
             sb.n_checked, sb.n_corrected);
    $display("over reset defaults and six register settings with stalls.");
    if (sb.n_errors == 0 && sb.pending_vel.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dcs_pkg.sv
rtl/core/dcs_regs.sv
rtl/core/dcs_front.sv
rtl/core/dcs_sqrt.sv
rtl/core/dcs_div.sv
rtl/core/dcs_back.sv
rtl/core/distance_constraint_solve.sv
verif/distance_constraint_solve_test.sv
